>>> rtl/core/shi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shi_pkg
// Shared types, codes and fixed-point constants of the sample history
// interpolator.
// ----------------------------------------------------------------------------
package shi_pkg;

	typedef enum logic [1:0] {
		FN_RECORD = 2'd0,
		FN_INTERP = 2'd1,
		FN_LATEST = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EMPTY       = 2'd1,
		ST_SINGLE      = 2'd2,
		ST_UNBRACKETED = 2'd3
	} status_t;

	typedef enum logic {
		CM_ROTATE = 1'b0,
		CM_VECTOR = 1'b1
	} cordic_mode_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_req_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MOD,
		CS_FOLD,
		CS_ITER,
		CS_DONE
	} cordic_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_RD1,
		S_SCAN0,
		S_SCAN,
		S_DIV,
		S_BL0,
		S_BL1,
		S_CA,
		S_CA_W,
		S_CB,
		S_CB_W,
		S_VG,
		S_VG_W,
		S_EMIT
	} shi_state_t;

	typedef enum logic [2:0] {
		BS_VEL,
		BS_EFF,
		BS_POS,
		BS_SIN,
		BS_COS
	} blend_sel_t;

	// Q4.28 angles, Q1.30 unit values
	localparam longint PI_Q28      = 64'd843314857;
	localparam longint HALF_PI_Q28 = 64'd421657428;
	localparam longint TWO_PI_Q28  = 64'd1686629713;
	localparam longint GAIN_Q30    = 64'd652032874;
	localparam longint ONE_Q30     = 64'd1073741824;
	localparam longint HALF_LSB30  = 64'd536870912;

	// cordic working width
	localparam int CW_BITS = 36;

	function automatic logic [29:0] atan_q28(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd210828714;
			5'd1:  v = 30'd124459457;
			5'd2:  v = 30'd65760959;
			5'd3:  v = 30'd33381290;
			5'd4:  v = 30'd16755422;
			5'd5:  v = 30'd8385879;
			5'd6:  v = 30'd4193963;
			5'd7:  v = 30'd2097109;
			5'd8:  v = 30'd1048571;
			5'd9:  v = 30'd524287;
			5'd10: v = 30'd262144;
			5'd11: v = 30'd131072;
			5'd12: v = 30'd65536;
			5'd13: v = 30'd32768;
			5'd14: v = 30'd16384;
			5'd15: v = 30'd8192;
			5'd16: v = 30'd4096;
			5'd17: v = 30'd2048;
			5'd18: v = 30'd1024;
			5'd19: v = 30'd512;
			5'd20: v = 30'd256;
			5'd21: v = 30'd128;
			5'd22: v = 30'd64;
			5'd23: v = 30'd32;
			5'd24: v = 30'd16;
			5'd25: v = 30'd8;
			5'd26: v = 30'd4;
			5'd27: v = 30'd2;
			5'd28: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/shi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shi_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module shi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/shi_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shi_cordic
// Iterative cordic: rotation gives cos and sin of a Q16.16 angle,
// vectoring gives the angle of a vector, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module shi_cordic import shi_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cordic_req_t                req,
	input  logic signed [31:0]         angle,
	input  logic signed [CW_BITS-1:0]  vx,
	input  logic signed [CW_BITS-1:0]  vy,
	output logic                       done,
	output logic signed [CW_BITS-1:0]  cx,
	output logic signed [CW_BITS-1:0]  cy,
	output logic signed [31:0]         angle_out
);

	localparam int IW = $clog2(STEPS);
	localparam logic [45:0] TWO_PI_BIG = 46'(TWO_PI_Q28 * 8192);

	cordic_state_t state_q, state_d;
	cordic_mode_t  mode_q;
	logic [45:0]   u_q;
	logic [3:0]    mi_q;
	logic [IW-1:0] i_q;
	logic          flip_q;
	logic signed [CW_BITS-1:0] x_q, y_q, z_q;

	logic [45:0] mod_cmp;
	logic signed [CW_BITS-1:0] r0, rs, dx, dy, at;
	logic sig_pos;
	logic signed [CW_BITS-1:0] zr;

	assign mod_cmp = 46'(TWO_PI_Q28) << mi_q;
	assign r0      = CW_BITS'($signed({1'b0, u_q[33:0]}));
	assign rs      = (r0 > CW_BITS'(PI_Q28)) ? r0 - CW_BITS'(TWO_PI_Q28) : r0;
	assign dx      = y_q >>> i_q;
	assign dy      = x_q >>> i_q;
	assign at      = CW_BITS'(atan_q28(5'(i_q)));
	assign sig_pos = (mode_q == CM_ROTATE) ? (z_q >= 0) : (y_q < 0);
	assign zr      = z_q + CW_BITS'(2048);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (req.start) begin
					if (req.mode == CM_ROTATE) begin
						state_d = CS_MOD;
					end else if (vx == 0 && vy == 0) begin
						state_d = CS_DONE;
					end else begin
						state_d = CS_ITER;
					end
				end
			end
			CS_MOD:  if (mi_q == 4'd0) state_d = CS_FOLD;
			CS_FOLD: state_d = CS_ITER;
			CS_ITER: if (i_q == IW'(STEPS - 1)) state_d = CS_DONE;
			CS_DONE: state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				mode_q <= req.mode;
				i_q    <= '0;
				mi_q   <= 4'd13;
				flip_q <= 1'b0;
				// offset by a multiple of 2pi so the reduction sees a positive value
				u_q    <= 46'($signed({{2{angle[31]}}, angle, 12'b0})) + TWO_PI_BIG;
				z_q    <= '0;
				x_q    <= vx;
				y_q    <= vy;
				if (req.mode == CM_VECTOR && vx < 0) begin
					z_q <= (vy >= 0) ? CW_BITS'(PI_Q28) : -CW_BITS'(PI_Q28);
					x_q <= -vx;
					y_q <= -vy;
				end
			end
			CS_MOD: begin
				if (u_q >= mod_cmp) u_q <= u_q - mod_cmp;
				mi_q <= mi_q - 4'd1;
			end
			CS_FOLD: begin
				x_q <= CW_BITS'(GAIN_Q30);
				y_q <= '0;
				if (rs > CW_BITS'(HALF_PI_Q28)) begin
					z_q    <= rs - CW_BITS'(PI_Q28);
					flip_q <= 1'b1;
				end else if (rs < -CW_BITS'(HALF_PI_Q28)) begin
					z_q    <= rs + CW_BITS'(PI_Q28);
					flip_q <= 1'b1;
				end else begin
					z_q <= rs;
				end
			end
			CS_ITER: begin
				if (sig_pos) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + IW'(1);
			end
			default: ;
		endcase
	end

	assign done      = (state_q == CS_DONE);
	assign cx        = flip_q ? -x_q : x_q;
	assign cy        = flip_q ? -y_q : y_q;
	assign angle_out = zr[43:12];

	logic unused_z;
	assign unused_z = ^zr[11:0] ^ ^zr[CW_BITS-1:44];

endmodule

>>> rtl/core/sample_history_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_history_interpolator_top
// Per-joint ring history of timestamped samples with linear and circular
// interpolation.
// ----------------------------------------------------------------------------
// Each joint owns a ring of MAX_POINTS-1 samples in one shared RAM (time,
// position, velocity and effort packed in one word). One item is handled at a
// time. An interpolate scans the ring from the oldest sample, one RAM read
// per cycle, then runs the bit-serial weight divider and the blends on one
// shared multiplier. A continuous joint adds three passes of the iterative
// cordic (two rotations, one vectoring). The RAM needs no clearing pass: a
// joint's fill count says which entries hold data.
// While a result waits in the output register the next item may already be
// taken and worked on; it only waits at the end for the register to free.
module sample_history_interpolator_top import shi_pkg::*; #(
	parameter int MAX_POINTS   = 1024,
	parameter int JOINTS       = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         joint,
	input  logic [62:0]        time_stamp,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] effort,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [62:0]        out_time,
	output logic signed [31:0] out_position,
	output logic signed [31:0] out_velocity,
	output logic signed [31:0] out_effort
);

	localparam int SW    = $clog2(MAX_POINTS);
	localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int DEPTH = JOINTS * MAX_POINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = 63 + 96;
	localparam int OW    = CW_BITS;

	// ---------------- configuration register ----------------
	logic [15:0] cont_mask_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'b0, cont_mask_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_mask_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			cont_mask_q <= pwdata[15:0];
		end
	end

	// ---------------- per-joint ring pointers ----------------
	logic [SW-1:0] oldest_q [JOINTS];
	logic [SW-1:0] cnt_q    [JOINTS];

	// ---------------- item latched on transfer ----------------
	func_t             func_q;
	logic [3:0]        joint_q;
	logic [62:0]       t_q;
	logic signed [31:0] pos_q, vel_q, eff_q;

	shi_state_t state_q, state_d;

	logic          accept;
	logic [JW+3:0] jx;
	logic [JW-1:0] jidx;
	logic          jvalid;
	logic [SW-1:0] n_cur, old_cur;
	logic          is_cont;

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign jx      = {{JW{1'b0}}, joint_q};
	assign jidx    = jx[JW-1:0];
	assign jvalid  = (jx < (JW + 4)'(JOINTS));
	assign n_cur   = jvalid ? cnt_q[jidx] : '0;
	assign old_cur = jvalid ? oldest_q[jidx] : '0;
	assign is_cont = cont_mask_q[joint_q];

	// ---------------- ring slot to RAM address ----------------
	logic [SW:0]   cur_q;
	logic [SW:0]   rd_k, wr_k;
	logic [SW:0]   rsum, wsum;
	logic [SW-1:0] rslot, wslot;
	logic [AW-1:0] raddr, waddr, jbase;

	// position k of the ring, counted from the oldest sample
	assign rsum  = {1'b0, old_cur} + rd_k;
	assign rslot = (rsum >= (SW + 1)'(MAX_POINTS)) ? SW'(rsum - (SW + 1)'(MAX_POINTS))
	                                              : rsum[SW-1:0];
	assign wr_k  = {1'b0, n_cur};
	assign wsum  = {1'b0, old_cur} + wr_k;
	assign wslot = (wsum >= (SW + 1)'(MAX_POINTS)) ? SW'(wsum - (SW + 1)'(MAX_POINTS))
	                                              : wsum[SW-1:0];
	assign jbase = AW'(jidx) * AW'(MAX_POINTS);
	assign raddr = jbase + AW'(rslot);
	assign waddr = jbase + AW'(wslot);

	always_comb begin
		rd_k = '0;
		unique case (state_q)
			S_DISP:  rd_k = (func_q == FN_LATEST) ? {1'b0, n_cur} - (SW + 1)'(1) : '0;
			S_SCAN0: rd_k = (SW + 1)'(1);
			S_SCAN:  rd_k = cur_q + (SW + 1)'(1);
			default: rd_k = '0;
		endcase
	end

	// ---------------- sample RAM ----------------
	logic          ram_we;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [62:0]   r_time;
	logic signed [31:0] r_pos, r_vel, r_eff;

	assign ram_we    = (state_q == S_DISP) && (func_q == FN_RECORD) && jvalid;
	assign ram_wdata = {t_q, pos_q, vel_q, eff_q};
	assign r_time    = ram_rdata[158:96];
	assign r_pos     = ram_rdata[95:64];
	assign r_vel     = ram_rdata[63:32];
	assign r_eff     = ram_rdata[31:0];

	shi_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// ring pointer update on a record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOINTS; j++) begin
				oldest_q[j] <= '0;
				cnt_q[j]    <= '0;
			end
		end else if (ram_we) begin
			if (n_cur == SW'(MAX_POINTS - 1)) begin
				// ring full: the oldest sample drops out
				oldest_q[jidx] <= (old_cur == SW'(MAX_POINTS - 1)) ? '0 : old_cur + SW'(1);
			end else begin
				cnt_q[jidx] <= n_cur + SW'(1);
			end
		end
	end

	// ---------------- scan: bracketing pair ----------------
	logic [62:0]        a_time;
	logic signed [31:0] a_pos, a_vel, a_eff;
	logic signed [31:0] b_pos, b_vel, b_eff;
	logic               hit, last_pair, same_t;

	assign hit       = (a_time <= t_q) && (r_time >= t_q);
	assign last_pair = (cur_q == {1'b0, n_cur} - (SW + 1)'(1));
	assign same_t    = (r_time == a_time);

	// ---------------- weight divider, one quotient bit per cycle ----------------
	logic [62:0] dn_q, dd_q, dr_q;
	logic [30:0] w_q;
	logic [4:0]  dc_q;
	logic [63:0] dr2;
	logic        dge;

	assign dr2 = {dr_q, 1'b0};
	assign dge = (dr2 >= {1'b0, dd_q});

	// ---------------- shared blend multiplier ----------------
	blend_sel_t            bsel_q;
	logic signed [OW-1:0]  bl_a, bl_b, bl_a_q;
	logic signed [OW:0]    bl_diff;
	logic signed [31:0]    w_s;
	logic signed [OW+32:0] prod_s1;
	logic signed [OW+32:0] prod_rnd, prod_sh;
	logic signed [OW-1:0]  bl_res;
	logic signed [OW-1:0]  ca_q, sa_q, cb_q, sb_q, bs_q, bc_q;

	always_comb begin
		bl_a = '0;
		bl_b = '0;
		unique case (bsel_q)
			BS_VEL: begin
				bl_a = OW'(a_vel);
				bl_b = OW'(b_vel);
			end
			BS_EFF: begin
				bl_a = OW'(a_eff);
				bl_b = OW'(b_eff);
			end
			BS_POS: begin
				bl_a = OW'(a_pos);
				bl_b = OW'(b_pos);
			end
			BS_SIN: begin
				bl_a = sa_q;
				bl_b = sb_q;
			end
			BS_COS: begin
				bl_a = ca_q;
				bl_b = cb_q;
			end
			default: ;
		endcase
	end

	assign bl_diff  = (OW + 1)'(bl_b) - (OW + 1)'(bl_a);
	assign w_s      = $signed({1'b0, w_q});
	assign prod_rnd = prod_s1 + (OW + 33)'(HALF_LSB30);
	assign prod_sh  = prod_rnd >>> 30;
	assign bl_res   = bl_a_q + prod_sh[OW-1:0];

	// ---------------- cordic ----------------
	cordic_req_t          creq;
	logic signed [31:0]   c_angle;
	logic signed [OW-1:0] c_vx, c_vy, c_x, c_y;
	logic                 c_done;
	logic signed [31:0]   c_ang_out;

	assign creq.start = (state_q == S_CA) || (state_q == S_CB) || (state_q == S_VG);
	assign creq.mode  = (state_q == S_VG) ? CM_VECTOR : CM_ROTATE;
	assign c_angle    = (state_q == S_CB) ? b_pos : a_pos;
	assign c_vx       = bc_q;
	assign c_vy       = bs_q;

	shi_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (creq),
		.angle    (c_angle),
		.vx       (c_vx),
		.vy       (c_vy),
		.done     (c_done),
		.cx       (c_x),
		.cy       (c_y),
		.angle_out(c_ang_out)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_DISP;
			S_DISP: begin
				priority if (func_q == FN_NONE || func_q == FN_RECORD) begin
					state_d = S_IDLE;
				end else if (n_cur == '0) begin
					state_d = S_EMIT;
				end else if (func_q == FN_LATEST || n_cur == SW'(1)) begin
					state_d = S_RD1;
				end else begin
					state_d = S_SCAN0;
				end
			end
			S_RD1:   state_d = S_EMIT;
			S_SCAN0: state_d = S_SCAN;
			S_SCAN: begin
				priority if (hit) begin
					state_d = same_t ? S_EMIT : S_DIV;
				end else if (last_pair) begin
					state_d = S_EMIT;
				end
			end
			S_DIV:   if (dc_q == 5'd0) state_d = S_BL0;
			S_BL0:   state_d = S_BL1;
			S_BL1: begin
				unique case (bsel_q)
					BS_VEL:  state_d = S_BL0;
					BS_EFF:  state_d = is_cont ? S_CA : S_BL0;
					BS_POS:  state_d = S_EMIT;
					BS_SIN:  state_d = S_BL0;
					BS_COS:  state_d = S_VG;
					default: state_d = S_EMIT;
				endcase
			end
			S_CA:    state_d = S_CA_W;
			S_CA_W:  if (c_done) state_d = S_CB;
			S_CB:    state_d = S_CB_W;
			S_CB_W:  if (c_done) state_d = S_BL0;
			S_VG:    state_d = S_VG_W;
			S_VG_W:  if (c_done) state_d = S_EMIT;
			S_EMIT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- datapath registers ----------------
	status_t            res_st_q;
	logic [62:0]        res_t_q;
	logic signed [31:0] res_pos_q, res_vel_q, res_eff_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			joint_q <= joint;
			t_q     <= time_stamp;
			pos_q   <= position;
			vel_q   <= velocity;
			eff_q   <= effort;
		end
		unique case (state_q)
			S_DISP: begin
				// empty history or joint out of range
				res_st_q  <= ST_EMPTY;
				res_t_q   <= t_q;
				res_pos_q <= '0;
				res_vel_q <= '0;
				res_eff_q <= '0;
			end
			S_RD1: begin
				res_st_q  <= (func_q == FN_LATEST) ? ST_OK : ST_SINGLE;
				res_t_q   <= r_time;
				res_pos_q <= r_pos;
				res_vel_q <= r_vel;
				res_eff_q <= r_eff;
			end
			S_SCAN0: begin
				a_time <= r_time;
				a_pos  <= r_pos;
				a_vel  <= r_vel;
				a_eff  <= r_eff;
				cur_q  <= (SW + 1)'(1);
			end
			S_SCAN: begin
				b_pos <= r_pos;
				b_vel <= r_vel;
				b_eff <= r_eff;
				dn_q  <= t_q - a_time;
				dd_q  <= r_time - a_time;
				dr_q  <= t_q - a_time;
				w_q   <= '0;
				dc_q  <= 5'd30;
				bsel_q <= BS_VEL;
				res_t_q <= t_q;
				priority if (hit) begin
					// equal bracketing times: later sample wins
					res_st_q  <= ST_OK;
					res_pos_q <= r_pos;
					res_vel_q <= r_vel;
					res_eff_q <= r_eff;
					if (t_q - a_time >= r_time - a_time) begin
						dc_q <= 5'd0;
						w_q  <= 31'(ONE_Q30);
					end
				end else if (last_pair) begin
					res_st_q  <= ST_UNBRACKETED;
					res_pos_q <= '0;
					res_vel_q <= '0;
					res_eff_q <= '0;
				end else begin
					a_time <= r_time;
					a_pos  <= r_pos;
					a_vel  <= r_vel;
					a_eff  <= r_eff;
					cur_q  <= cur_q + (SW + 1)'(1);
				end
			end
			S_DIV: begin
				if (dc_q != 5'd0) begin
					dr_q <= dge ? 63'(dr2 - {1'b0, dd_q}) : dr2[62:0];
					w_q  <= {w_q[29:0], dge};
					dc_q <= dc_q - 5'd1;
				end
			end
			S_BL0: begin
				bl_a_q  <= bl_a;
				prod_s1 <= bl_diff * w_s;
			end
			S_BL1: begin
				unique case (bsel_q)
					BS_VEL: begin
						res_vel_q <= bl_res[31:0];
						bsel_q    <= BS_EFF;
					end
					BS_EFF: begin
						res_eff_q <= bl_res[31:0];
						bsel_q    <= is_cont ? BS_SIN : BS_POS;
					end
					BS_POS: res_pos_q <= bl_res[31:0];
					BS_SIN: begin
						bs_q   <= bl_res;
						bsel_q <= BS_COS;
					end
					BS_COS: bc_q <= bl_res;
					default: ;
				endcase
			end
			S_CA_W: begin
				ca_q <= c_x;
				sa_q <= c_y;
			end
			S_CB_W: begin
				cb_q <= c_x;
				sb_q <= c_y;
			end
			S_VG_W: res_pos_q <= c_ang_out;
			default: ;
		endcase
	end

	logic unused_dn;
	assign unused_dn = ^dn_q;

	// ---------------- output register ----------------
	logic load_out;
	assign load_out = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status       <= res_st_q;
			out_time     <= res_t_q;
			out_position <= res_pos_q;
			out_velocity <= res_vel_q;
			out_effort   <= res_eff_q;
		end
	end

endmodule
